@@ design/firmata_receive_parser_macros.svh @@
// Assertion macros shared by the receive parser.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef FIRMATA_RECEIVE_PARSER_MACROS_SVH
`define FIRMATA_RECEIVE_PARSER_MACROS_SVH

// Same-cycle implication.
`define FRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/frp_pkg.sv @@
package frp_pkg;

    localparam int SYSEX_DEPTH_DEF = 64;

    localparam logic [7:0] TOP_MASK               = 8'hF0;
    localparam logic [7:0] CMD_ANALOG_TOP         = 8'hE0;
    localparam logic [7:0] CMD_DIGITAL_TOP        = 8'h90;
    localparam logic [7:0] CMD_REPORT_ANALOG_TOP  = 8'hC0;
    localparam logic [7:0] CMD_REPORT_DIGITAL_TOP = 8'hD0;
    localparam logic [7:0] CMD_REPORT_VERSION     = 8'hF9;
    localparam logic [7:0] CMD_START_SYSEX        = 8'hF0;
    localparam logic [7:0] CMD_END_SYSEX          = 8'hF7;
    localparam logic [7:0] SYSEX_FIRMWARE         = 8'h79;

    typedef enum logic [1:0] {
        KIND_ANALOG,
        KIND_DIGITAL,
        KIND_NAME,
        KIND_VERSION
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PAIR,
        S_LO,
        S_HI,
        S_VER
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  take;
        logic  init_idx;
        logic  step_idx;
        logic  rd_hi;
        logic  cap_lo;
        logic  load_out;
        t_kind kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic complete;
        logic is_analog;
        logic is_digital;
        logic is_fw;
        logic more_pairs;
        logic out_free;
    } t_stat;

endpackage

@@ design/frp_ctrl.sv @@
module frp_ctrl
    import frp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_stat  i_stat,
    output t_cmd   o_cmd,
    output logic   o_stall,
    output t_state o_state
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_stat.complete) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.is_analog || i_stat.is_digital) begin
                    if (i_stat.out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (i_stat.is_fw) begin
                    n_state = S_PAIR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAIR: begin
                n_state = i_stat.more_pairs ? S_LO : S_VER;
            end
            S_LO: begin
                n_state = S_HI;
            end
            S_HI: begin
                if (i_stat.out_free) begin
                    n_state = S_PAIR;
                end
            end
            S_VER: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_cmd.kind = KIND_ANALOG;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.take = i_valid;
            end
            S_CHECK: begin
                o_cmd.init_idx = 1'b1;
                o_cmd.kind     = i_stat.is_digital ? KIND_DIGITAL : KIND_ANALOG;
                o_cmd.load_out = (i_stat.is_analog || i_stat.is_digital) && i_stat.out_free;
            end
            S_PAIR: begin
                o_cmd.rd_hi = 1'b0;
            end
            S_LO: begin
                o_cmd.cap_lo = 1'b1;
                o_cmd.rd_hi  = 1'b1;
            end
            S_HI: begin
                o_cmd.rd_hi    = 1'b1;
                o_cmd.kind     = KIND_NAME;
                o_cmd.load_out = i_stat.out_free;
                o_cmd.step_idx = i_stat.out_free;
            end
            S_VER: begin
                o_cmd.kind     = KIND_VERSION;
                o_cmd.load_out = i_stat.out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

    assign o_state = r_state;

endmodule

@@ design/frp_datapath.sv @@
module frp_datapath
    import frp_pkg::*;
#(
    parameter int SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_stall,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_channel,
    output logic [13:0] o_value,
    output logic [7:0]  o_name_char,
    output logic [7:0]  o_major,
    output logic [7:0]  o_minor,
    output logic        o_last
);

    localparam int CW = $clog2(SYSEX_DEPTH + 1);
    localparam int AW = $clog2(SYSEX_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(SYSEX_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);
    localparam logic [CW-1:0] THREE_C = CW'(3);
    localparam logic [CW-1:0] FOUR_C  = CW'(4);

    logic [CW-1:0] r_exp;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_msg_len;
    logic [CW-1:0] r_idx;
    logic [7:0]    r_last_byte;
    logic [7:0]    r_head [0:3];
    logic [7:0]    r_mem [0:SYSEX_DEPTH-1];
    logic [7:0]    r_rd_data;
    logic [7:0]    r_lo;

    logic          r_out_valid;
    t_kind         r_kind;
    logic [3:0]    r_channel;
    logic [13:0]   r_value;
    logic [7:0]    r_name_char;
    logic [7:0]    r_major;
    logic [7:0]    r_minor;
    logic          r_last;

    logic [3:0]    n_channel;
    logic [13:0]   n_value;
    logic [7:0]    n_name_char;
    logic [7:0]    n_major;
    logic [7:0]    n_minor;
    logic          n_last;

    logic [7:0]    rx_top;
    logic [CW-1:0] f_exp;
    logic [CW-1:0] f_cnt;
    logic [CW-1:0] cnt_inc;
    logic          drop;
    logic          guard;
    logic          wr;
    logic          complete;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          out_free;
    logic [13:0]   word;

    assign rx_top = i_rx_byte & TOP_MASK;

    // Framing decision for the byte on the input port.
    always_comb begin
        f_exp = r_exp;
        f_cnt = r_cnt;
        drop  = 1'b0;
        if (rx_top == CMD_ANALOG_TOP || rx_top == CMD_DIGITAL_TOP ||
            i_rx_byte == CMD_REPORT_VERSION) begin
            f_exp = THREE_C;
            f_cnt = '0;
        end else if (rx_top == CMD_REPORT_ANALOG_TOP || rx_top == CMD_REPORT_DIGITAL_TOP) begin
            f_exp = TWO_C;
            f_cnt = '0;
        end else if (i_rx_byte == CMD_START_SYSEX) begin
            f_exp = DEPTH_C;
            f_cnt = '0;
        end else if (i_rx_byte == CMD_END_SYSEX) begin
            f_exp = r_cnt + ONE_C;
        end else if (i_rx_byte[7]) begin
            f_exp = ONE_C;
            f_cnt = '0;
        end else if (r_exp == '0) begin
            drop = 1'b1;
        end
    end

    assign guard    = (f_cnt >= DEPTH_C) || (f_cnt >= f_exp);
    assign wr       = !drop && !guard;
    assign cnt_inc  = f_cnt + ONE_C;
    assign complete = wr && (cnt_inc == f_exp);
    assign wr_addr  = f_cnt[AW-1:0];
    assign rd_addr  = r_idx[AW-1:0] + AW'(i_cmd.rd_hi);
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
            r_cnt <= '0;
        end else if (i_cmd.take && !drop) begin
            if (guard || complete) begin
                r_exp <= '0;
                r_cnt <= '0;
            end else begin
                r_exp <= f_exp;
                r_cnt <= cnt_inc;
            end
        end
    end

    // Message store; the first four entries are mirrored in registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && wr) begin
            r_mem[wr_addr] <= i_rx_byte;
            if (f_cnt < FOUR_C) begin
                r_head[f_cnt[1:0]] <= i_rx_byte;
            end
        end
        if (i_cmd.take && complete) begin
            r_msg_len   <= cnt_inc;
            r_last_byte <= i_rx_byte;
        end
        r_rd_data <= r_mem[rd_addr];
        if (i_cmd.cap_lo) begin
            r_lo <= r_rd_data;
        end
        if (i_cmd.init_idx) begin
            r_idx <= FOUR_C;
        end else if (i_cmd.step_idx) begin
            r_idx <= r_idx + TWO_C;
        end
    end

    assign word = {r_last_byte[6:0], 7'b0} | {6'b0, r_head[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result fields for the kind being loaded; unused fields read as zero.
    always_comb begin
        n_channel   = '0;
        n_value     = '0;
        n_name_char = '0;
        n_major     = '0;
        n_minor     = '0;
        n_last      = 1'b1;
        unique case (i_cmd.kind)
            KIND_ANALOG: begin
                n_channel = r_head[0][3:0];
                n_value   = word;
            end
            KIND_DIGITAL: begin
                n_channel = r_head[0][3:0];
                n_value   = {6'b0, word[7:0]};
            end
            KIND_NAME: begin
                n_name_char = {r_rd_data[0], r_lo[6:0]};
                n_last      = 1'b0;
            end
            KIND_VERSION: begin
                n_major = r_head[2];
                n_minor = r_head[3];
            end
            default: n_last = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_kind      <= i_cmd.kind;
            r_channel   <= n_channel;
            r_value     <= n_value;
            r_name_char <= n_name_char;
            r_major     <= n_major;
            r_minor     <= n_minor;
            r_last      <= n_last;
        end
    end

    assign o_stat.complete   = complete;
    assign o_stat.is_analog  = (r_msg_len == THREE_C) && ((r_head[0] & TOP_MASK) == CMD_ANALOG_TOP);
    assign o_stat.is_digital = (r_msg_len == THREE_C) && ((r_head[0] & TOP_MASK) == CMD_DIGITAL_TOP);
    assign o_stat.is_fw      = (r_head[0] == CMD_START_SYSEX) && (r_last_byte == CMD_END_SYSEX) &&
                               (r_head[1] == SYSEX_FIRMWARE) && (r_msg_len >= TWO_C);
    assign o_stat.more_pairs = ({1'b0, r_idx} + (CW+1)'(2)) < {1'b0, r_msg_len};
    assign o_stat.out_free   = out_free;

    assign o_valid     = r_out_valid;
    assign o_kind      = r_kind;
    assign o_channel   = r_channel;
    assign o_value     = r_value;
    assign o_name_char = r_name_char;
    assign o_major     = r_major;
    assign o_minor     = r_minor;
    assign o_last      = r_last;

endmodule

@@ design/firmata_receive_parser.sv @@
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_stall   i_rx_byte
// result    out        o_valid / i_stall   o_kind o_channel o_value o_name_char
//                                          o_major o_minor o_last
//
// A received byte that does not finish a message leaves the decoder idle for the next request.
// A byte that finishes a message moves the decoder to S_CHECK; an analog or digital
// result is loaded into the output register as S_CHECK ends.
// A firmware report then steps through S_PAIR, S_LO and S_HI for each name character
// (one memory read each for the low and high half) and through S_PAIR and S_VER for the version.
// Reset is synchronous and active low; the message store is not cleared.
// A stall on the result side holds the decoder wherever a result must be loaded.
module firmata_receive_parser
    import frp_pkg::*;
#(
    parameter int SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_channel,
    output logic [13:0] o_value,
    output logic [7:0]  o_name_char,
    output logic [7:0]  o_major,
    output logic [7:0]  o_minor,
    output logic        o_last
);

    t_cmd   s_cmd;
    t_stat  s_stat;
    t_state s_state;

    // The controller walks the decode of a finished message; it takes a new
    // request only while it is idle.
    frp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (s_stat),
        .o_cmd   (s_cmd),
        .o_stall (o_stall),
        .o_state (s_state)
    );

    // The datapath frames bytes into the store, reads character pairs back
    // and owns the output register.
    frp_datapath #(
        .SYSEX_DEPTH (SYSEX_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (i_rx_byte),
        .i_stall     (i_stall),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_channel   (o_channel),
        .o_value     (o_value),
        .o_name_char (o_name_char),
        .o_major     (o_major),
        .o_minor     (o_minor),
        .o_last      (o_last)
    );

`include "firmata_receive_parser_macros.svh"

    // A result is loaded only when the previous one is gone or leaving.
    `FRP_ASSERT_NOW(a_load_free, s_cmd.load_out, s_stat.out_free, "result loaded over pending result")
    // A loaded result shows up on the port in the next cycle.
    `FRP_ASSERT_NEXT(a_load_shown, s_cmd.load_out, o_valid, "loaded result not presented")
    // The version result always closes a firmware report.
    `FRP_ASSERT_NOW(a_version_last, o_valid && (o_kind == KIND_VERSION), o_last, "version without last")
    // A name character is never the final result, and no request enters mid-decode.
    `FRP_ASSERT_NOW(a_name_busy, o_valid && (o_kind == KIND_NAME), !o_last, "name char marked last")
    `FRP_ASSERT_NOW(a_take_idle, s_cmd.take, s_state == S_IDLE, "request taken while decoding")

endmodule

@@ bench/firmata_receive_parser_test.sv @@
module firmata_receive_parser_test;
    import frp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Store depth of the instance below (default parameter).
    localparam int DEPTH = SYSEX_DEPTH_DEF;

    // Bit mask of the byte format that the package does not name.
    localparam logic [7:0] CMD_FLAG  = 8'h80;

    // Items the random part aims at, not counting bytes the block just drops.
    localparam int unsigned RANDOM_ITEMS = 290;
    // The receiver holds off once for this long, so the output side backs up
    // into the decoder and finally into o_stall.
    localparam int unsigned HOLD_CYCLES  = 400;
    // Long enough for a full-size firmware report to walk through; allow for stalls.
    localparam int unsigned TAIL_CYCLES  = 300;
    // Cycles without any accepted request or result before the run is aborted.
    localparam int unsigned STUCK_LIMIT  = 4000;

    // One decoded result as it leaves the block.
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  channel;
        logic [13:0] value;
        logic [7:0]  name_char;
        logic [7:0]  major;
        logic [7:0]  minor;
        logic        last;
    } frame_result_t;

    // Frames received bytes the same way the block does and keeps the results
    // that are still owed by it, oldest first.
    class frame_checker;
        int unsigned   want_len;
        int unsigned   got_len;
        logic [7:0]    frame_store [DEPTH];
        frame_result_t due_results [$];
        int unsigned   errors;
        int unsigned   byte_count;
        int unsigned   result_count;
        int unsigned   kind_count [4];

        function void push_result(t_kind kind, logic [3:0] channel, logic [13:0] value,
                                  logic [7:0] name_char, logic [7:0] major,
                                  logic [7:0] minor, logic last);
            frame_result_t r;
            r.kind      = kind;
            r.channel   = channel;
            r.value     = value;
            r.name_char = name_char;
            r.major     = major;
            r.minor     = minor;
            r.last      = last;
            due_results.push_back(r);
        endfunction

        // A message of n bytes is complete; work out what it produces.
        function void decode_frame(int unsigned n);
            logic [7:0]  first;
            logic [7:0]  top;
            logic [20:0] word;
            int unsigned i;
            first = frame_store[0];
            top   = first & TOP_MASK;
            if (n == 3 && (top == CMD_ANALOG_TOP || top == CMD_DIGITAL_TOP)) begin
                // The two 7-bit halves overlap at bit 7 when the first data
                // byte has its top bit set.
                word = {6'b0, frame_store[2], 7'b0} | {13'b0, frame_store[1]};
                if (top == CMD_ANALOG_TOP) begin
                    push_result(KIND_ANALOG, first[3:0], word[13:0], 8'h00, 8'h00, 8'h00, 1'b1);
                end else begin
                    push_result(KIND_DIGITAL, first[3:0], {6'b0, word[7:0]}, 8'h00, 8'h00,
                                8'h00, 1'b1);
                end
            end else if (first == CMD_START_SYSEX && n >= 2 && n <= DEPTH &&
                         frame_store[n - 1] == CMD_END_SYSEX &&
                         frame_store[1] == SYSEX_FIRMWARE) begin
                for (i = 4; i + 2 < n; i += 2) begin
                    push_result(KIND_NAME, 4'h0, 14'h0000,
                                {frame_store[i + 1][0], frame_store[i][6:0]},
                                8'h00, 8'h00, 1'b0);
                end
                push_result(KIND_VERSION, 4'h0, 14'h0000, 8'h00, frame_store[2],
                            frame_store[3], 1'b1);
            end
        endfunction

        // Called once for every request the block accepts.
        function void take_byte(logic [7:0] b);
            logic [7:0] top;
            top = b & TOP_MASK;
            byte_count++;
            if (top == CMD_ANALOG_TOP || top == CMD_DIGITAL_TOP || b == CMD_REPORT_VERSION) begin
                want_len = 3;
                got_len  = 0;
            end else if (top == CMD_REPORT_ANALOG_TOP || top == CMD_REPORT_DIGITAL_TOP) begin
                want_len = 2;
                got_len  = 0;
            end else if (b == CMD_START_SYSEX) begin
                want_len = DEPTH;
                got_len  = 0;
            end else if (b == CMD_END_SYSEX) begin
                want_len = got_len + 1;
            end else if ((b & CMD_FLAG) != 0) begin
                want_len = 1;
                got_len  = 0;
            end else if (want_len == 0) begin
                return;
            end
            if (got_len >= DEPTH || got_len >= want_len) begin
                want_len = 0;
                got_len  = 0;
                return;
            end
            frame_store[got_len] = b;
            got_len++;
            if (got_len == want_len) begin
                decode_frame(got_len);
                want_len = 0;
                got_len  = 0;
            end
        endfunction

        // Called once for every result the block hands over.
        function void match_result(frame_result_t got);
            frame_result_t want;
            if (due_results.size() == 0) begin
                $error("result kind %0d arrived with none outstanding", got.kind);
                errors++;
                return;
            end
            want = due_results.pop_front();
            result_count++;
            kind_count[want.kind]++;
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.channel !== want.channel) begin
                $error("channel: expected %0d, got %0d", want.channel, got.channel);
                errors++;
            end
            if (got.value !== want.value) begin
                $error("value: expected 0x%h, got 0x%h", want.value, got.value);
                errors++;
            end
            if (got.name_char !== want.name_char) begin
                $error("name_char: expected 0x%h, got 0x%h", want.name_char, got.name_char);
                errors++;
            end
            if (got.major !== want.major) begin
                $error("major: expected 0x%h, got 0x%h", want.major, got.major);
                errors++;
            end
            if (got.minor !== want.minor) begin
                $error("minor: expected 0x%h, got 0x%h", want.minor, got.minor);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [3:0]  o_channel;
    logic [13:0] o_value;
    logic [7:0]  o_name_char;
    logic [7:0]  o_major;
    logic [7:0]  o_minor;
    logic        o_last;

    frame_checker tracker = new();

    // Bytes to send, with the number of idle cycles in front of each one.
    logic [7:0]  rx_plan [$];
    int unsigned gap_plan [$];
    // While set, bytes go out back to back.
    bit          burst;
    int unsigned idle_cycles;

    firmata_receive_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_channel   (o_channel),
        .o_value     (o_value),
        .o_name_char (o_name_char),
        .o_major     (o_major),
        .o_minor     (o_minor),
        .o_last      (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // A protocol data byte: top bit clear.
    function automatic logic [7:0] data7();
        return 8'($urandom_range(0, 127));
    endfunction

    // Queue one byte. Most gaps are short; a few are long enough to let the
    // block drain completely between two bytes of the same message.
    function automatic void push_byte(logic [7:0] b);
        int unsigned r;
        int unsigned gap;
        r = $urandom_range(0, 99);
        if (burst || r < 50) begin
            gap = 0;
        end else if (r < 85) begin
            gap = $urandom_range(1, 3);
        end else if (r < 97) begin
            gap = $urandom_range(4, 10);
        end else begin
            gap = $urandom_range(20, 60);
        end
        rx_plan.push_back(b);
        gap_plan.push_back(gap);
    endfunction

    // Offer one request and hold it until the block takes it. Inputs change
    // only at the rising edge, and o_stall is read right after the edge, so
    // the value seen is the one that decided the handshake at that edge.
    task automatic send_request(input logic [7:0] b, input int unsigned gap);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.take_byte(b);
    endtask

    // Result side: compare every result taken from the block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.match_result({t_kind'(o_kind), o_channel, o_value, o_name_char,
                                  o_major, o_minor, o_last});
        end
    end

    // Watchdog: a correct block never goes this long without moving a request
    // or a result, even through the long hold-off below.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STUCK_LIMIT) begin
            $display("Stuck for %0d cycles with %0d results outstanding.",
                     STUCK_LIMIT, tracker.due_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, mostly short, some long, with stretches where
    // it never stalls. Once, after a good part of the traffic, it holds off
    // for a long stretch so that the block fills up and stalls its input.
    initial begin
        int unsigned stall_len;
        int unsigned ready_len;
        int unsigned r;
        bit          held;
        held = 1'b0;
        repeat (6) @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (!held && tracker.byte_count >= 120) begin
                held      = 1'b1;
                stall_len = HOLD_CYCLES;
            end else if (r < 40) begin
                stall_len = 0;
            end else if (r < 85) begin
                stall_len = $urandom_range(1, 3);
            end else if (r < 97) begin
                stall_len = $urandom_range(4, 12);
            end else begin
                stall_len = $urandom_range(20, 60);
            end
            if (stall_len != 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            ready_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 8);
            i_stall <= 1'b0;
            repeat (ready_len) @(posedge i_clk);
        end
    end

    // Sender and run control.
    initial begin
        int unsigned sel;
        int unsigned m;
        int unsigned i;
        int unsigned ignored;
        int unsigned directed_len;
        int unsigned overflows;
        logic [7:0]  b;

        ignored   = 0;
        overflows = 0;
        burst     = 1'b0;

        // Directed part. The first message is a full firmware report, so the
        // store entries that a short report reads back are written early.
        // Name character built from 0x7F and 0x01: every bit set.
        push_byte(CMD_START_SYSEX);
        push_byte(SYSEX_FIRMWARE);
        push_byte(8'h02);
        push_byte(8'h05);
        push_byte(8'h7F);
        push_byte(8'h01);
        push_byte(CMD_END_SYSEX);
        // Analog on channel 0 with the largest value.
        push_byte(CMD_ANALOG_TOP);
        push_byte(8'h7F);
        push_byte(8'h7F);
        // Digital on the highest port; bit 0 of the second byte lands on pin 7.
        push_byte(CMD_DIGITAL_TOP | 8'h0F);
        push_byte(8'h55);
        push_byte(8'h01);
        // A data byte with no message open is dropped.
        push_byte(8'h7F);
        // End sysex closing a short message counts as its last data byte.
        push_byte(CMD_ANALOG_TOP | 8'h0F);
        push_byte(8'h00);
        push_byte(CMD_END_SYSEX);
        // An analog message cut short by a report-analog command.
        push_byte(CMD_ANALOG_TOP | 8'h03);
        push_byte(8'h10);
        push_byte(CMD_REPORT_ANALOG_TOP | 8'h05);
        push_byte(8'h20);
        // Short firmware report: the version comes from what the store holds.
        push_byte(CMD_START_SYSEX);
        push_byte(SYSEX_FIRMWARE);
        push_byte(CMD_END_SYSEX);
        // A stray end sysex and a plain one-byte command: both silent.
        push_byte(CMD_END_SYSEX);
        push_byte(CMD_FLAG);
        directed_len = rx_plan.size();

        // Random part: mostly well-formed messages with random content, the
        // rest cut-off messages, stray commands and noise.
        while (rx_plan.size() - ignored < directed_len + RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 4) == 0);
            sel   = $urandom_range(0, 99);
            if (sel < 20) begin
                push_byte(CMD_ANALOG_TOP | 8'($urandom_range(0, 15)));
                push_byte(data7());
                push_byte(($urandom_range(0, 9) == 0) ? CMD_END_SYSEX : data7());
            end else if (sel < 35) begin
                push_byte(CMD_DIGITAL_TOP | 8'($urandom_range(0, 15)));
                push_byte(data7());
                push_byte(($urandom_range(0, 9) == 0) ? CMD_END_SYSEX : data7());
            end else if (sel < 40) begin
                push_byte(CMD_REPORT_VERSION);
                push_byte(data7());
                push_byte(data7());
            end else if (sel < 48) begin
                push_byte((($urandom_range(0, 1) == 0) ? CMD_REPORT_ANALOG_TOP
                                                      : CMD_REPORT_DIGITAL_TOP)
                          | 8'($urandom_range(0, 15)));
                push_byte(data7());
            end else if (sel < 63) begin
                // Firmware report; most names are short, a few fill the store.
                m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, DEPTH - 5)
                                                : $urandom_range(0, 8);
                push_byte(CMD_START_SYSEX);
                push_byte(SYSEX_FIRMWARE);
                push_byte(data7());
                push_byte(data7());
                for (i = 0; i < m; i++) push_byte(data7());
                push_byte(CMD_END_SYSEX);
            end else if (sel < 67) begin
                // Firmware report too short to carry a name character.
                m = $urandom_range(0, 2);
                push_byte(CMD_START_SYSEX);
                push_byte(SYSEX_FIRMWARE);
                for (i = 0; i < m; i++) push_byte(data7());
                push_byte(CMD_END_SYSEX);
            end else if (sel < 72) begin
                // Some other sysex, possibly empty.
                m = $urandom_range(0, 6);
                push_byte(CMD_START_SYSEX);
                for (i = 0; i < m; i++) begin
                    b = data7();
                    push_byte((i == 0 && b == SYSEX_FIRMWARE) ? 8'h00 : b);
                end
                push_byte(CMD_END_SYSEX);
            end else if (sel < 80) begin
                // A message abandoned partway; the next one starts with a command.
                case ($urandom_range(0, 4))
                    0: push_byte(CMD_ANALOG_TOP | 8'($urandom_range(0, 15)));
                    1: push_byte(CMD_DIGITAL_TOP | 8'($urandom_range(0, 15)));
                    2: push_byte(CMD_REPORT_VERSION);
                    3: push_byte(CMD_REPORT_DIGITAL_TOP | 8'($urandom_range(0, 15)));
                    default: begin
                        push_byte(CMD_START_SYSEX);
                        push_byte(SYSEX_FIRMWARE);
                        push_byte(data7());
                    end
                endcase
                m = $urandom_range(0, 1);
                for (i = 0; i < m; i++) push_byte(data7());
                push_byte(8'($urandom_range(128, 255)));
            end else if (sel < 86) begin
                m = $urandom_range(1, 4);
                for (i = 0; i < m; i++) push_byte(data7());
                ignored += m;
            end else if (sel < 95) begin
                push_byte(8'($urandom_range(128, 255)));
            end else if (sel < 99 || overflows >= 2) begin
                m = $urandom_range(1, 3);
                for (i = 0; i < m; i++) push_byte(8'($urandom_range(0, 255)));
            end else begin
                // Sysex that fills the store without an end byte; the data
                // bytes after it arrive with no message open.
                overflows++;
                push_byte(CMD_START_SYSEX);
                for (i = 1; i < DEPTH; i++) push_byte(data7());
                m = $urandom_range(1, 3);
                for (i = 0; i < m; i++) push_byte(data7());
                ignored += m;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rx_plan[k]) send_request(rx_plan[k], gap_plan[k]);
        i_valid <= 1'b0;

        // Drain, then watch a while longer for results nobody asked for.
        while (tracker.due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (%0d directed, %0d sysex overflows); checked %0d results.",
                 tracker.byte_count, directed_len, overflows, tracker.result_count);
        $display("Results: %0d analog, %0d digital, %0d name characters, %0d versions.",
                 tracker.kind_count[KIND_ANALOG], tracker.kind_count[KIND_DIGITAL],
                 tracker.kind_count[KIND_NAME], tracker.kind_count[KIND_VERSION]);
        if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
